>>> hdl/mdt_pkg.sv
// Shared constants for the maximum drawdown tracker.
`timescale 1ns / 1ps

package mdt_pkg;

   // Default widths of the equity sample and of the sample counter
   localparam int VALUE_WIDTH_DEF = 48;
   localparam int INDEX_WIDTH_DEF = 32;

   // Drawdown result format: 32-bit signed, 24 fractional bits
   localparam int DD_WIDTH = 32;
   localparam int DD_FRAC  = 24;

   // Integer quotient bits below the saturation point, and quotient bits produced
   localparam int INT_BITS = DD_WIDTH - 1 - DD_FRAC;
   localparam int QUO_BITS = DD_WIDTH - 1;

   // Magnitude that a saturated drawdown takes (-2^31 once negated)
   localparam logic [DD_WIDTH-1:0] DD_MAG_MAX = {1'b1, {(DD_WIDTH-1){1'b0}}};

   // Percent scaling: times 100, then drop 8 fractional bits (24 -> 16)
   localparam int PCT_SCALE = 100;
   localparam int PCT_SHIFT = DD_FRAC - 16;
   localparam int PROD_W    = DD_WIDTH + 7;

   // Width of the recovery count port
   localparam int RCV_WIDTH = 32;

endpackage

>>> hdl/max_drawdown_tracker_unit.sv
// Top level of the maximum drawdown tracker with its bit-serial divider.
`timescale 1ns / 1ps

// Maximum drawdown tracker.
// The req_ channel takes one equity sample per item (signed fixed point) and a
// series_start flag that clears all tracking and loads the peak from the sample.
// Every item yields exactly one item on the rsp_ channel: the worst relative
// drawdown so far, that drawdown times 100, the recovery period in samples,
// and a flag that is high while the series holds fewer than two samples.
// Timing: the drawdown ratio comes from a restoring divider that produces one
// quotient bit per cycle in a shift register, 31 bits in all. An accepted item
// passes through the setup, divide and done states; rsp_valid and req_ready
// rise at the same edge, when the result is committed to the output register.
// The block works on one item at a time; req_ready is high only while it is
// free. A finished result sits in the output register, and the next item is
// taken while it waits. If the receiver stalls, the next result is held back
// in its last step until the output register is free.
// Reset (synchronous, active high) drops rsp_valid, idles the divider and
// clears the sample count, so the first item after reset opens a new series.
module max_drawdown_tracker_unit #(
   parameter int VALUE_WIDTH = mdt_pkg::VALUE_WIDTH_DEF,
   parameter int INDEX_WIDTH = mdt_pkg::INDEX_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [VALUE_WIDTH-1:0]        req_equity,
   input  logic                                 req_series_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [mdt_pkg::DD_WIDTH-1:0]  rsp_drawdown,
   output logic signed [mdt_pkg::DD_WIDTH-1:0]  rsp_drawdown_percent,
   output logic [mdt_pkg::RCV_WIDTH-1:0]        rsp_recovery_samples,
   output logic                                 rsp_too_few_samples
);

   localparam int DW    = mdt_pkg::DD_WIDTH;
   localparam int QB    = mdt_pkg::QUO_BITS;
   localparam int IB    = mdt_pkg::INT_BITS;
   localparam int RW    = mdt_pkg::RCV_WIDTH;
   localparam int CNT_W = $clog2(QB);
   localparam int CW    = (INDEX_WIDTH > RW) ? INDEX_WIDTH : RW;

   typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_DIV, ST_DONE} state_type;

   state_type                     state_ff, state_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                          start_ff, start_in;
   logic signed [VALUE_WIDTH-1:0] peak_ff, peak_in;
   logic signed [VALUE_WIDTH-1:0] peak_new_ff, peak_new_in;
   logic [DW-1:0]                 worst_ff, worst_in;
   logic signed [VALUE_WIDTH-1:0] paw_ff, paw_in;
   logic [INDEX_WIDTH-1:0]        widx_ff, widx_in;
   logic [INDEX_WIDTH-1:0]        idx_ff, idx_in;
   logic [INDEX_WIDTH-1:0]        here_ff, here_in;
   logic                          rec_ff, rec_in;
   logic [INDEX_WIDTH-1:0]        rcnt_ff, rcnt_in;
   logic                          first_ff, first_in;
   logic                          sat_ff, sat_in;
   logic                          pos_ff, pos_in;
   logic [VALUE_WIDTH-2:0]        den_ff, den_in;
   logic [VALUE_WIDTH-2:0]        rem_ff, rem_in;
   logic [QB-1:0]                 dvd_ff, dvd_in;
   logic [QB-1:0]                 quo_ff, quo_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                 rsp_dd_ff, rsp_dd_in;
   logic [DW-1:0]                 rsp_pct_ff, rsp_pct_in;
   logic [RW-1:0]                 rsp_rcv_ff, rsp_rcv_in;
   logic                          rsp_few_ff, rsp_few_in;

   // Setup-step signals
   logic                          first_now;
   logic signed [VALUE_WIDTH-1:0] base_peak;
   logic signed [VALUE_WIDTH-1:0] new_peak;
   logic [VALUE_WIDTH-1:0]        num;

   // Divider step signals
   logic [VALUE_WIDTH-1:0]        trial;
   logic [VALUE_WIDTH-1:0]        diff;
   logic                          ge;

   // Commit-step signals
   logic                          commit;
   logic [DW-1:0]                 mag;
   logic [DW-1:0]                 b_worst;
   logic [INDEX_WIDTH-1:0]        b_widx;
   logic signed [VALUE_WIDTH-1:0] b_paw;
   logic                          b_rec;
   logic [INDEX_WIDTH-1:0]        b_rcnt;
   logic [mdt_pkg::PROD_W-1:0]    prod;
   logic [CW-1:0]                 rcnt_ext;

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drawdown         = signed'(rsp_dd_ff);
   assign rsp_drawdown_percent = signed'(rsp_pct_ff);
   assign rsp_recovery_samples = rsp_rcv_ff;
   assign rsp_too_few_samples  = rsp_few_ff;

   // Peak update and divider operands for the item in hand
   always_comb begin
      first_now = start_ff || (idx_ff == '0);
      base_peak = first_now ? value_ff : peak_ff;
      new_peak  = (value_ff > base_peak) ? value_ff : base_peak;
      num       = VALUE_WIDTH'($unsigned(new_peak - value_ff));
   end

   // One restoring-division step: shift in a dividend bit, trial subtract
   always_comb begin
      trial = {rem_ff, dvd_ff[QB-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
   end

   // Select the saturated or divided magnitude (zero for a non-positive peak), then fold it into the tracking
   always_comb begin
      commit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      if (!pos_ff) begin
         mag = '0;
      end else if (sat_ff) begin
         mag = mdt_pkg::DD_MAG_MAX;
      end else begin
         mag = {1'b0, quo_ff};
      end
      b_worst = first_ff ? '0 : worst_ff;
      b_widx  = first_ff ? '0 : widx_ff;
      b_paw   = first_ff ? '0 : paw_ff;
      b_rec   = first_ff ? 1'b0 : rec_ff;
      b_rcnt  = first_ff ? '0 : rcnt_ff;
   end

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      start_in     = start_ff;
      peak_in      = peak_ff;
      peak_new_in  = peak_new_ff;
      worst_in     = worst_ff;
      paw_in       = paw_ff;
      widx_in      = widx_ff;
      idx_in       = idx_ff;
      here_in      = here_ff;
      rec_in       = rec_ff;
      rcnt_in      = rcnt_ff;
      first_in     = first_ff;
      sat_in       = sat_ff;
      pos_in       = pos_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dd_in    = rsp_dd_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_rcv_in   = rsp_rcv_ff;
      rsp_few_in   = rsp_few_ff;
      prod         = '0;
      rcnt_ext     = '0;

      case (state_ff)
         ST_IDLE: begin
            // Capture the item
            if (req_valid) begin
               value_in = req_equity;
               start_in = req_series_start;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // Update the peak and load the divider
            first_in    = first_now;
            peak_new_in = new_peak;
            here_in     = first_now ? '0 : idx_ff;
            pos_in      = (new_peak > 0);
            den_in      = new_peak[VALUE_WIDTH-2:0];
            sat_in      = ({{IB{1'b0}}, num} >= {1'b0, new_peak[VALUE_WIDTH-2:0], {IB{1'b0}}});
            rem_in      = (VALUE_WIDTH-1)'(num >> IB);
            dvd_in      = {num[IB-1:0], {mdt_pkg::DD_FRAC{1'b0}}};
            quo_in      = '0;
            cnt_in      = '0;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            // Advance one quotient bit
            rem_in = ge ? diff[VALUE_WIDTH-2:0] : trial[VALUE_WIDTH-2:0];
            quo_in = {quo_ff[QB-2:0], ge};
            dvd_in = {dvd_ff[QB-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QB - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free, then commit
            if (commit) begin
               peak_in  = peak_new_ff;
               worst_in = b_worst;
               paw_in   = b_paw;
               widx_in  = b_widx;
               rec_in   = b_rec;
               rcnt_in  = b_rcnt;
               if (mag > b_worst) begin
                  worst_in = mag;
                  paw_in   = peak_new_ff;
                  widx_in  = here_ff;
                  rec_in   = 1'b0;
                  rcnt_in  = '0;
               end else if ((b_worst != '0) && !b_rec && (value_ff >= b_paw)) begin
                  rec_in  = 1'b1;
                  rcnt_in = here_ff - b_widx;
               end
               idx_in = (here_ff == '1) ? here_ff : here_ff + 1'b1;

               prod     = mdt_pkg::PROD_W'(worst_in) * mdt_pkg::PROD_W'(mdt_pkg::PCT_SCALE);
               rcnt_ext = CW'(rcnt_in);

               rsp_valid_in = 1'b1;
               rsp_dd_in    = '0 - worst_in;
               rsp_pct_in   = '0 - DW'(prod >> mdt_pkg::PCT_SHIFT);
               rsp_rcv_in   = (rcnt_ext > CW'({RW{1'b1}})) ? '1 : rcnt_ext[RW-1:0];
               rsp_few_in   = (idx_in < INDEX_WIDTH'(2));
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
      value_ff    <= value_in;
      start_ff    <= start_in;
      peak_ff     <= peak_in;
      peak_new_ff <= peak_new_in;
      worst_ff    <= worst_in;
      paw_ff      <= paw_in;
      widx_ff     <= widx_in;
      here_ff     <= here_in;
      rec_ff      <= rec_in;
      rcnt_ff     <= rcnt_in;
      first_ff    <= first_in;
      sat_ff      <= sat_in;
      pos_ff      <= pos_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      rsp_dd_ff   <= rsp_dd_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_rcv_ff  <= rsp_rcv_in;
      rsp_few_ff  <= rsp_few_in;
   end

endmodule

>>> hdl/mdt_checker.sv
// Port-level checks for the maximum drawdown tracker, bound to the top level.
`timescale 1ns / 1ps

module mdt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [mdt_pkg::DD_WIDTH-1:0] rsp_drawdown,
   input logic signed [mdt_pkg::DD_WIDTH-1:0] rsp_drawdown_percent,
   input logic [mdt_pkg::RCV_WIDTH-1:0]       rsp_recovery_samples
);

   // Reset drops any pending result
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // One item at a time: busy right after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while the divider is busy");

   // Worst drawdown is never positive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drawdown[mdt_pkg::DD_WIDTH-1] || (rsp_drawdown == '0)))
      else $error("positive drawdown reported");

   // No drawdown means no percent and no recovery period
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_drawdown == '0)) |->
         ((rsp_drawdown_percent == '0) && (rsp_recovery_samples == '0)))
      else $error("percent or recovery set without a drawdown");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_drawdown)
         && $stable(rsp_recovery_samples)))
      else $error("stalled result changed");

endmodule

bind max_drawdown_tracker_unit mdt_checker u_mdt_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_drawdown         (rsp_drawdown),
   .rsp_drawdown_percent (rsp_drawdown_percent),
   .rsp_recovery_samples (rsp_recovery_samples)
);
